FILE: rtl/smx_pkg.sv
// package: shared constants and codes of the sample playback mixer
`timescale 1ns / 1ps
`default_nettype none
package smx_pkg;

    localparam int P_VOICES       = 48;
    localparam int P_SAMPLE_WORDS = 65536;
    localparam int P_FRAC_BITS    = 16;

    localparam logic [15:0] UNITY       = 16'd32768;
    localparam logic [15:0] FLOOR_RESET = 16'd164;
    localparam logic [15:0] ROUND_Q15   = 16'd16384;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_WORLD = 2'd1;
    localparam logic [1:0] CMD_MUSIC = 2'd2;
    localparam logic [1:0] CMD_MIX   = 2'd3;

    localparam logic [1:0] REG_WORLD_VOL = 2'd0;
    localparam logic [1:0] REG_MUSIC_VOL = 2'd1;
    localparam logic [1:0] REG_FLOOR     = 2'd2;

    localparam logic [1:0] STAT_DONE     = 2'd0;
    localparam logic [1:0] STAT_NO_VOICE = 2'd1;
    localparam logic [1:0] STAT_QUIET    = 2'd2;

endpackage
`default_nettype wire

FILE: rtl/smx_in_if.sv
// interface: command channel into the mixer
`timescale 1ns / 1ps
`default_nettype none
interface smx_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [15:0]        sample_addr;
    logic signed [15:0] sample_value;
    logic [15:0]        clip_base;
    logic [16:0]        clip_frames;
    logic               clip_stereo;
    logic [20:0]        step;
    logic [15:0]        gain;
    logic signed [15:0] pan;

    modport source (output valid, cmd, sample_addr, sample_value, clip_base, clip_frames,
                    clip_stereo, step, gain, pan, input ready);
    modport sink (input valid, cmd, sample_addr, sample_value, clip_base, clip_frames,
                  clip_stereo, step, gain, pan, output ready);
endinterface
`default_nettype wire

FILE: rtl/smx_out_if.sv
// interface: result channel out of the mixer
`timescale 1ns / 1ps
`default_nettype none
interface smx_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic [1:0]         status;
    logic               music_active;
    logic [5:0]         active_voices;

    modport source (output valid, left_out, right_out, status, music_active, active_voices,
                    input ready);
    modport sink (input valid, left_out, right_out, status, music_active, active_voices,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/smx_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none
module smx_mul #(
    parameter int A_W = 34,
    parameter int B_W = 17
) (
    input  wire logic                     i_clk,
    input  wire logic signed [A_W-1:0]    i_a,
    input  wire logic signed [B_W-1:0]    i_b,
    output logic signed [A_W+B_W-1:0]     o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end
endmodule
`default_nettype wire

FILE: rtl/smx_sample_ram.sv
// sample store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module smx_sample_ram #(
    parameter int ADDR_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [15:0]       i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic [15:0]            o_rdata
);
    logic [15:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/smx_voice_ram.sv
// voice record store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module smx_voice_ram #(
    parameter int DEPTH  = 48,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 120
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0]      o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/multi_voice_sample_mixer.sv
// top level: sequencer, voice state and mix datapath of the sample playback mixer
//
//  channel   dir  handshake          contents
//  i_in      in   valid/ready        cmd, sample, clip, step, gain, pan
//  o_out     out  valid/ready        left/right frame, status, voice counts
//  i_cfg_*   in   write enable only  world volume, music volume, audible floor
//
// one command at a time; ready only while the sequencer is idle
// sample write, music start and a world start below the floor: straight from idle to done
// world start: left and right gain products, then a scan of voices 1 to VOICES-1 for a free one
// mix: idle voices are skipped, ending voices retired, playing voices interpolated left then right, one multiplier
// a finished result waits in the output register; a full register holds the sequencer
// synchronous active-low reset clears voices, counters, sequencer state and configuration; store is not cleared
`timescale 1ns / 1ps
`default_nettype none
module multi_voice_sample_mixer #(
    parameter int VOICES       = smx_pkg::P_VOICES,
    parameter int SAMPLE_WORDS = smx_pkg::P_SAMPLE_WORDS,
    parameter int FRAC_BITS    = smx_pkg::P_FRAC_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    smx_in_if.sink     i_in,
    smx_out_if.source  o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    import smx_pkg::*;

    localparam int F      = FRAC_BITS;
    localparam int VIW    = $clog2(VOICES);
    localparam int CNTW   = $clog2(VOICES + 1);
    localparam int SAW    = $clog2(SAMPLE_WORDS);
    localparam int CW     = F + 17;
    localparam int VW     = 16 + 17 + 1 + CW + 21 + 16 + 16;
    localparam int SW     = F + 18;
    localparam int MA     = SW;
    localparam int MB     = (F + 1 > 17) ? F + 1 : 17;
    localparam int PW     = MA + MB;
    localparam int TW     = F + 35;
    localparam int SH     = F + 15;
    localparam int ACC_W  = F + 43;
    localparam logic [VIW-1:0] LAST_V = VIW'(VOICES - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WG1  = 4'd1;
    localparam logic [3:0] S_WG2  = 4'd2;
    localparam logic [3:0] S_WG3  = 4'd3;
    localparam logic [3:0] S_FIND = 4'd4;
    localparam logic [3:0] S_MRD  = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_E1   = 4'd7;
    localparam logic [3:0] S_E2   = 4'd8;
    localparam logic [3:0] S_D    = 4'd9;
    localparam logic [3:0] S_S    = 4'd10;
    localparam logic [3:0] S_P    = 4'd11;
    localparam logic [3:0] S_ACC  = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (SH - 1);
    localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'(-32768);

    logic [3:0]         r_state;
    logic [VIW-1:0]     r_v;
    logic [VOICES-1:0]  r_active;
    logic [CNTW-1:0]    r_count;
    logic [15:0]        r_world_vol;
    logic [15:0]        r_music_vol;
    logic [15:0]        r_floor;
    logic [1:0]         r_cmd;
    logic [1:0]         r_status;
    logic [15:0]        r_base;
    logic [16:0]        r_frames;
    logic               r_stereo;
    logic [20:0]        r_step;
    logic [15:0]        r_g;
    logic signed [15:0] r_pan;
    logic [15:0]        r_lg;
    logic [15:0]        r_rg;
    logic [15:0]        r_el;
    logic [15:0]        r_er;
    logic [SAW-1:0]     r_pa;
    logic signed [15:0] r_a;
    logic signed [15:0] r_b;
    logic signed [15:0] r_ar;
    logic signed [15:0] r_br;
    logic signed [SW-1:0] r_s;
    logic               r_ear;
    logic signed [ACC_W-1:0] r_accl;
    logic signed [ACC_W-1:0] r_accr;
    logic               r_ovalid;

    logic               w_acc_in;
    logic [15:0]        w_gin;
    logic [15:0]        w_pl;
    logic [16:0]        w_pr;
    logic [15:0]        w_ul;
    logic [15:0]        w_ur;
    logic [15:0]        w_bus;
    logic [VW-1:0]      w_vrd;
    logic [15:0]        w_vbase;
    logic [16:0]        w_vframes;
    logic               w_vstereo;
    logic [CW-1:0]      w_vcursor;
    logic [20:0]        w_vstep;
    logic [15:0]        w_vlg;
    logic [15:0]        w_vrg;
    logic [16:0]        w_idx;
    logic [F-1:0]       w_frac;
    logic               w_ended;
    logic [19:0]        w_pa_full;
    logic [SAW-1:0]     w_ch;
    logic               w_vwe;
    logic [VIW-1:0]     w_vaddr;
    logic [VW-1:0]      w_vwdata;
    logic               w_swe;
    logic [SAW-1:0]     w_sraddr;
    logic [15:0]        w_srdata;
    logic signed [MA-1:0] w_ma;
    logic signed [MB-1:0] w_mb;
    logic signed [PW-1:0] w_prod;
    logic [31:0]        w_rnd;
    logic [15:0]        w_gain_q;
    logic signed [16:0] w_diff;
    logic signed [TW-1:0] w_term;
    logic signed [SW-1:0] w_interp;
    logic               w_out_free;
    logic [CNTW+5:0]    w_cnt_ext;

    function automatic logic signed [15:0] settle(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] v;
        logic signed [ACC_W-1:0] q;
        v = acc + $signed(RND_HALF);
        q = v >>> SH;
        if (q > Q_MAX) begin
            settle = 16'sh7fff;
        end else if (q < Q_MIN) begin
            settle = 16'sh8000;
        end else begin
            settle = q[15:0];
        end
    endfunction

    assign w_acc_in = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // world start gains
    assign w_gin = (i_in.gain > UNITY) ? UNITY : i_in.gain;
    assign w_pl  = (r_pan > 16'sd0) ? r_pan : 16'd0;
    assign w_pr  = (r_pan < 16'sd0) ? 17'(-{r_pan[15], r_pan}) : 17'd0;
    assign w_ul  = 16'(17'(UNITY) - {1'b0, w_pl});
    assign w_ur  = 16'(17'(UNITY) - w_pr);

    assign w_bus = (r_v == '0) ? r_music_vol : r_world_vol;

    assign {w_vbase, w_vframes, w_vstereo, w_vcursor, w_vstep, w_vlg, w_vrg} = w_vrd;
    assign w_idx     = w_vcursor[CW-1:F];
    assign w_frac    = w_vcursor[F-1:0];
    assign w_ended   = ({1'b0, w_idx} + 18'd1) >= {1'b0, w_vframes};
    assign w_pa_full = {4'd0, w_vbase}
                     + (w_vstereo ? {2'd0, w_idx, 1'b0} : {3'd0, w_idx});
    assign w_ch      = w_vstereo ? SAW'(2) : SAW'(1);

    assign w_rnd    = 32'(w_prod[31:0]) + 32'(ROUND_Q15);
    assign w_gain_q = w_rnd[30:15];
    assign w_diff   = 17'(r_b) - 17'(r_a);
    assign w_term   = w_prod[TW-1:0];
    assign w_interp = (SW'(r_a) <<< F) + $signed(w_prod[SW-1:0]);

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_WG1: begin
                w_ma = MA'($signed({1'b0, r_g}));
                w_mb = MB'($signed({1'b0, w_ul}));
            end
            S_WG2: begin
                w_ma = MA'($signed({1'b0, r_g}));
                w_mb = MB'($signed({1'b0, w_ur}));
            end
            S_CHK: begin
                w_ma = MA'($signed({1'b0, w_vlg}));
                w_mb = MB'($signed({1'b0, w_bus}));
            end
            S_E1: begin
                w_ma = MA'($signed({1'b0, w_vrg}));
                w_mb = MB'($signed({1'b0, w_bus}));
            end
            S_D: begin
                w_ma = MA'(w_diff);
                w_mb = MB'($signed({1'b0, w_frac}));
            end
            S_P: begin
                w_ma = r_s;
                w_mb = MB'($signed({1'b0, r_ear ? r_er : r_el}));
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // sample store port select
    always_comb begin
        w_swe    = w_acc_in && (i_in.cmd == CMD_WRITE);
        w_sraddr = r_pa;
        unique case (r_state)
            S_CHK:   w_sraddr = SAW'(w_pa_full);
            S_E1:    w_sraddr = r_pa + w_ch;
            S_E2:    w_sraddr = r_pa + SAW'(1);
            S_D:     w_sraddr = r_pa + w_ch + SAW'(1);
            default: w_sraddr = r_pa;
        endcase
    end

    // voice store port select
    always_comb begin
        w_vwe    = 1'b0;
        w_vaddr  = r_v;
        w_vwdata = {w_vbase, w_vframes, w_vstereo, w_vcursor + CW'(w_vstep),
                    w_vstep, w_vlg, w_vrg};
        if (w_acc_in && (i_in.cmd == CMD_MUSIC)) begin
            w_vwe    = 1'b1;
            w_vaddr  = '0;
            w_vwdata = {i_in.clip_base, i_in.clip_frames, i_in.clip_stereo, CW'(0),
                        i_in.step, UNITY, UNITY};
        end else if ((r_state == S_FIND) && !r_active[r_v]) begin
            w_vwe    = 1'b1;
            w_vwdata = {r_base, r_frames, r_stereo, CW'(0), r_step, r_lg, r_rg};
        end else if ((r_state == S_ACC) && r_ear) begin
            w_vwe    = 1'b1;
        end
    end

    assign w_out_free = !r_ovalid || o_out.ready;
    assign w_cnt_ext  = (CNTW + 6)'(r_count);

    smx_mul #(
        .A_W (MA),
        .B_W (MB)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    smx_sample_ram #(
        .ADDR_W (SAW)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (w_swe),
        .i_waddr (SAW'(i_in.sample_addr)),
        .i_wdata (i_in.sample_value),
        .i_raddr (w_sraddr),
        .o_rdata (w_srdata)
    );

    smx_voice_ram #(
        .DEPTH  (VOICES),
        .ADDR_W (VIW),
        .DATA_W (VW)
    ) u_voice_ram (
        .i_clk   (i_clk),
        .i_we    (w_vwe),
        .i_waddr (w_vaddr),
        .i_wdata (w_vwdata),
        .i_raddr (r_v),
        .o_rdata (w_vrd)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_world_vol <= UNITY;
            r_music_vol <= UNITY;
            r_floor     <= FLOOR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WORLD_VOL: r_world_vol <= (i_cfg_data > UNITY) ? UNITY : i_cfg_data;
                REG_MUSIC_VOL: r_music_vol <= (i_cfg_data > UNITY) ? UNITY : i_cfg_data;
                REG_FLOOR:     r_floor     <= i_cfg_data;
                default:       r_floor     <= r_floor;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_v      <= '0;
            r_active <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_status <= STAT_DONE;
            r_cmd    <= CMD_WRITE;
            r_ear    <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        r_cmd    <= i_in.cmd;
                        r_base   <= i_in.clip_base;
                        r_frames <= i_in.clip_frames;
                        r_stereo <= i_in.clip_stereo;
                        r_step   <= i_in.step;
                        r_g      <= w_gin;
                        r_pan    <= i_in.pan;
                        r_status <= STAT_DONE;
                        r_accl   <= '0;
                        r_accr   <= '0;
                        r_v      <= '0;
                        unique case (i_in.cmd)
                            CMD_WRITE: r_state <= S_DONE;
                            CMD_WORLD: begin
                                if (w_gin < r_floor) begin
                                    r_status <= STAT_QUIET;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_WG1;
                                end
                            end
                            CMD_MUSIC: begin
                                r_active[0] <= 1'b1;
                                if (!r_active[0]) begin
                                    r_count <= r_count + CNTW'(1);
                                end
                                r_state <= S_DONE;
                            end
                            CMD_MIX:   r_state <= S_MRD;
                            default:   r_state <= S_DONE;
                        endcase
                    end
                end
                S_WG1: r_state <= S_WG2;
                S_WG2: begin
                    r_lg    <= w_gain_q;
                    r_state <= S_WG3;
                end
                S_WG3: begin
                    r_rg    <= w_gain_q;
                    r_v     <= VIW'(1);
                    r_state <= S_FIND;
                end
                S_FIND: begin
                    if (!r_active[r_v]) begin
                        r_active[r_v] <= 1'b1;
                        r_count       <= r_count + CNTW'(1);
                        r_state       <= S_DONE;
                    end else if (r_v == LAST_V) begin
                        r_status <= STAT_NO_VOICE;
                        r_state  <= S_DONE;
                    end else begin
                        r_v <= r_v + VIW'(1);
                    end
                end
                S_MRD: begin
                    if (r_active[r_v]) begin
                        r_state <= S_CHK;
                    end else if (r_v == LAST_V) begin
                        r_state <= S_DONE;
                    end else begin
                        r_v <= r_v + VIW'(1);
                    end
                end
                S_CHK: begin
                    if (w_ended) begin
                        r_active[r_v] <= 1'b0;
                        r_count       <= r_count - CNTW'(1);
                        if (r_v == LAST_V) begin
                            r_state <= S_DONE;
                        end else begin
                            r_v     <= r_v + VIW'(1);
                            r_state <= S_MRD;
                        end
                    end else begin
                        r_pa    <= SAW'(w_pa_full);
                        r_state <= S_E1;
                    end
                end
                S_E1: begin
                    r_el    <= w_gain_q;
                    r_a     <= w_srdata;
                    r_state <= S_E2;
                end
                S_E2: begin
                    r_er    <= w_gain_q;
                    r_b     <= w_srdata;
                    r_ear   <= 1'b0;
                    r_state <= S_D;
                end
                S_D: begin
                    if (!r_ear) begin
                        r_ar <= w_vstereo ? w_srdata : r_a;
                    end
                    r_state <= S_S;
                end
                S_S: begin
                    r_s <= w_interp;
                    if (!r_ear) begin
                        r_br <= w_vstereo ? w_srdata : r_b;
                    end
                    r_state <= S_P;
                end
                S_P: r_state <= S_ACC;
                S_ACC: begin
                    if (!r_ear) begin
                        r_accl  <= r_accl + ACC_W'(w_term);
                        r_a     <= r_ar;
                        r_b     <= r_br;
                        r_ear   <= 1'b1;
                        r_state <= S_D;
                    end else begin
                        r_accr <= r_accr + ACC_W'(w_term);
                        if (r_v == LAST_V) begin
                            r_state <= S_DONE;
                        end else begin
                            r_v     <= r_v + VIW'(1);
                            r_state <= S_MRD;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            o_out.left_out      <= (r_cmd == CMD_MIX) ? settle(r_accl) : 16'sd0;
            o_out.right_out     <= (r_cmd == CMD_MIX) ? settle(r_accr) : 16'sd0;
            o_out.status        <= r_status;
            o_out.music_active  <= r_active[0];
            o_out.active_voices <= (w_cnt_ext > (CNTW + 6)'(63)) ? 6'd63 : w_cnt_ext[5:0];
        end
    end

    assign o_out.valid = r_ovalid;

endmodule
`default_nettype wire
